// ===== hdl/gcq_pkg.sv =====
// gcq_pkg: shared types, codes and default sizes for the grouped class queue
// used by gcq_order and grouped_class_queue_core; depends on nothing
`timescale 1ns / 1ps

package gcq_pkg;

  localparam int NUM_CLASSES_DEF = 4;
  localparam int CLASS_DEPTH_DEF = 1024;
  localparam int TAG_WIDTH_DEF   = 16;

  localparam int ACT_W = 1;
  localparam int CLS_W = 3;
  localparam int TAG_W = 16;
  localparam int STS_W = 2;

  localparam logic [ACT_W-1:0] ACT_ENQ = 1'b0;
  localparam logic [ACT_W-1:0] ACT_DEQ = 1'b1;

  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [CLS_W-1:0] class_id;
    logic [TAG_W-1:0] tag;
  } in_word_t;

  typedef struct packed {
    logic [CLS_W-1:0] out_class;
    logic [TAG_W-1:0] out_tag;
    logic [STS_W-1:0] status;
  } out_word_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ord_ctl_t;

endpackage

// ===== hdl/gcq_ram.sv =====
// gcq_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module gcq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/gcq_order.sv =====
// gcq_order: circular queue of class indices in arrival order
// uses gcq_pkg for the control struct
`timescale 1ns / 1ps

module gcq_order #(
  parameter int NUM_CLASSES = gcq_pkg::NUM_CLASSES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  gcq_pkg::ord_ctl_t              ctl,
  input  logic [$clog2(NUM_CLASSES)-1:0] push_cls,
  output logic [$clog2(NUM_CLASSES)-1:0] front,
  output logic                           empty
);

  localparam int CI_W = $clog2(NUM_CLASSES);
  localparam int OC_W = $clog2(NUM_CLASSES + 1);
  localparam int SW   = OC_W + 1;

  logic [CI_W-1:0] q_r [NUM_CLASSES];
  logic [CI_W-1:0] head_r, head_nxt;
  logic [OC_W-1:0] count_r, count_nxt;
  logic [SW-1:0]   tail_sum, head_sum;
  logic [CI_W-1:0] tail;
  logic            can_push;

  assign tail_sum = SW'(head_r) + SW'(count_r);
  assign tail     = (tail_sum >= SW'(NUM_CLASSES)) ? CI_W'(tail_sum - SW'(NUM_CLASSES))
                                                   : CI_W'(tail_sum);
  assign head_sum = SW'(head_r) + SW'(1);
  assign can_push = ctl.push && (count_r < OC_W'(NUM_CLASSES));

  assign front = q_r[head_r];
  assign empty = (count_r == '0);

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (can_push) begin
      count_nxt = count_r + OC_W'(1);
    end else if (ctl.pop && !empty) begin
      head_nxt  = (head_sum >= SW'(NUM_CLASSES)) ? CI_W'(head_sum - SW'(NUM_CLASSES))
                                                 : CI_W'(head_sum);
      count_nxt = count_r - OC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_push) begin
      q_r[tail] <= push_cls;
    end
  end

endmodule

// ===== hdl/grouped_class_queue_core.sv =====
// grouped_class_queue_core: per-class fifos in one entry ram, pointers in one ram
// depends on gcq_pkg, gcq_ram and gcq_order
// enqueue: busy rises in the cycle after accept; a full-class drop result is registered out of S_PTR
// dequeue: result is registered out of S_OUT, reached through S_PTR; an empty dequeue answers in the cycle after accept
// busy spans the pointer ram read-modify-write (S_PTR) and, for a dequeue, the entry ram read
//   (S_OUT); no new request is accepted while busy, and results cannot be stalled
// reset (rst_n low, synchronous) empties every class fifo and the order queue; rams keep data
`timescale 1ns / 1ps

module grouped_class_queue_core #(
  parameter int NUM_CLASSES = gcq_pkg::NUM_CLASSES_DEF,
  parameter int CLASS_DEPTH = gcq_pkg::CLASS_DEPTH_DEF,
  parameter int TAG_WIDTH   = gcq_pkg::TAG_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  gcq_pkg::in_word_t  in_word,
  output logic               out_valid,
  output gcq_pkg::out_word_t out_word
);

  localparam int CI_W = $clog2(NUM_CLASSES);
  localparam int HD_W = $clog2(CLASS_DEPTH);
  localparam int CT_W = $clog2(CLASS_DEPTH + 1);
  localparam int SW   = CT_W + 1;
  localparam int PW   = HD_W + CT_W;
  localparam int EA_W = $clog2(NUM_CLASSES * CLASS_DEPTH);
  localparam int ST_W = (TAG_WIDTH < gcq_pkg::TAG_W) ? TAG_WIDTH : gcq_pkg::TAG_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PTR  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]               state_r, state_nxt;
  logic [gcq_pkg::ACT_W-1:0] act_r, act_nxt;
  logic [CI_W-1:0]          c_r, c_nxt;
  logic [ST_W-1:0]          tag_r, tag_nxt;
  logic                     out_valid_r, out_valid_nxt;
  gcq_pkg::out_word_t       out_word_r, out_word_nxt;
  logic [NUM_CLASSES-1:0]   ptr_vld_r;
  logic                     ptr_rvld_r;

  logic                     accept;
  logic                     cls_ok;
  logic [CI_W-1:0]          in_c;
  logic [CI_W-1:0]          ord_front;
  logic                     ord_empty;
  gcq_pkg::ord_ctl_t        ord_ctl;

  logic [CI_W-1:0]          ptr_raddr;
  logic [PW-1:0]            ptr_rdata;
  logic                     ptr_we;
  logic [PW-1:0]            ptr_wdata;
  logic [HD_W-1:0]          head;
  logic [CT_W-1:0]          count;
  logic [SW-1:0]            tail_sum, head_sum;
  logic [HD_W-1:0]          tail, head_inc;
  logic [EA_W-1:0]          base;

  logic                     ent_we;
  logic [EA_W-1:0]          ent_waddr, ent_raddr;
  logic [ST_W-1:0]          ent_rdata;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign cls_ok = (in_word.class_id != '0) &&
                  (32'(in_word.class_id) <= 32'(NUM_CLASSES));
  assign in_c   = CI_W'(in_word.class_id - gcq_pkg::CLS_W'(1));

  assign ptr_raddr = (in_word.action == gcq_pkg::ACT_ENQ) ? in_c : ord_front;

  assign head  = ptr_rvld_r ? ptr_rdata[PW-1:CT_W] : '0;
  assign count = ptr_rvld_r ? ptr_rdata[CT_W-1:0] : '0;

  assign tail_sum = SW'(head) + SW'(count);
  assign tail     = (tail_sum >= SW'(CLASS_DEPTH)) ? HD_W'(tail_sum - SW'(CLASS_DEPTH))
                                                   : HD_W'(tail_sum);
  assign head_sum = SW'(head) + SW'(1);
  assign head_inc = (head_sum >= SW'(CLASS_DEPTH)) ? HD_W'(head_sum - SW'(CLASS_DEPTH))
                                                   : HD_W'(head_sum);

  assign base      = EA_W'(c_r) * EA_W'(CLASS_DEPTH);
  assign ent_waddr = base + EA_W'(tail);
  assign ent_raddr = base + EA_W'(head);

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    c_nxt         = c_r;
    tag_nxt       = tag_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    ptr_we        = 1'b0;
    ptr_wdata     = {head, count};
    ent_we        = 1'b0;
    ord_ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_nxt = in_word.action;
          c_nxt   = ptr_raddr;
          tag_nxt = in_word.tag[ST_W-1:0];
          if (in_word.action == gcq_pkg::ACT_DEQ) begin
            if (ord_empty) begin
              out_valid_nxt          = 1'b1;
              out_word_nxt.out_class = '0;
              out_word_nxt.out_tag   = '0;
              out_word_nxt.status    = gcq_pkg::STS_EMPTY;
            end else begin
              state_nxt = S_PTR;
            end
          end else if (cls_ok) begin
            state_nxt = S_PTR;
          end
        end
      end
      S_PTR: begin
        state_nxt = S_IDLE;
        if (act_r == gcq_pkg::ACT_ENQ) begin
          if (32'(count) >= 32'(CLASS_DEPTH)) begin
            out_valid_nxt          = 1'b1;
            out_word_nxt.out_class = gcq_pkg::CLS_W'(c_r) + gcq_pkg::CLS_W'(1);
            out_word_nxt.out_tag   = gcq_pkg::TAG_W'(tag_r);
            out_word_nxt.status    = gcq_pkg::STS_FULL;
          end else begin
            ptr_we       = 1'b1;
            ptr_wdata    = {head, count + CT_W'(1)};
            ent_we       = 1'b1;
            ord_ctl.push = (count == '0);
          end
        end else if (count == '0) begin
          out_valid_nxt          = 1'b1;
          out_word_nxt.out_class = '0;
          out_word_nxt.out_tag   = '0;
          out_word_nxt.status    = gcq_pkg::STS_EMPTY;
        end else begin
          ptr_we      = 1'b1;
          ptr_wdata   = {head_inc, count - CT_W'(1)};
          ord_ctl.pop = (count == CT_W'(1));
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        state_nxt              = S_IDLE;
        out_valid_nxt          = 1'b1;
        out_word_nxt.out_class = gcq_pkg::CLS_W'(c_r) + gcq_pkg::CLS_W'(1);
        out_word_nxt.out_tag   = gcq_pkg::TAG_W'(ent_rdata);
        out_word_nxt.status    = gcq_pkg::STS_OK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ptr_vld_r   <= '0;
      ptr_rvld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ptr_rvld_r  <= ptr_vld_r[ptr_raddr];
      if (ptr_we) begin
        ptr_vld_r[c_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    c_r        <= c_nxt;
    tag_r      <= tag_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  gcq_order #(
    .NUM_CLASSES(NUM_CLASSES)
  ) u_order (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ord_ctl),
    .push_cls (c_r),
    .front    (ord_front),
    .empty    (ord_empty)
  );

  gcq_ram #(
    .WIDTH(PW),
    .DEPTH(NUM_CLASSES)
  ) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (c_r),
    .wdata (ptr_wdata),
    .raddr (ptr_raddr),
    .rdata (ptr_rdata)
  );

  gcq_ram #(
    .WIDTH(ST_W),
    .DEPTH(NUM_CLASSES * CLASS_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (tag_r),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result word strobed while an item is in flight");

  a_out_from_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |-> $past(state_r) == S_PTR)
    else $error("output state not entered from pointer state");

  a_ptr_we: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_we |-> state_r == S_PTR && !(ord_ctl.push && ord_ctl.pop))
    else $error("pointer write outside read-modify-write step");

  a_deq_go: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_word.action == gcq_pkg::ACT_DEQ && !ord_empty |=> state_r == S_PTR)
    else $error("dequeue of a non-empty queue did not read pointers");

endmodule
